// ----- src/ssag_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssag_pkg
// Shared types and constants of the strided slice address generator.
// ----------------------------------------------------------------------------
package ssag_pkg;

  // Configuration register map
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned CountW    = 16;
  localparam int unsigned OutIdxW   = 32;

  localparam logic [CfgIdxW-1:0] CFG_BASE_INDEX = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_STRIDE_X   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_STRIDE_Y   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_STRIDE_Z   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_COUNT_X    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_COUNT_Y    = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_COUNT_Z    = 3'd6;

  // Command queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Head of the command queue as seen by the back end
  typedef struct packed {
    logic valid;
    logic restart;
  } q_head_t;

endpackage

// ----- src/ssag_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssag_front
// Accepts request items and queues their commands for the back end.
// ----------------------------------------------------------------------------
module ssag_front
  import ssag_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  logic    restart_i,
  output q_head_t head_o,
  input  logic    pop_i
);

  logic [QDepth-1:0] slot_q;
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  count_q, count_d;
  logic              push;

  assign in_ready_o = (count_q != QCntW'(QDepth));
  assign push       = in_valid_i && in_ready_o;

  assign head_o.valid   = (count_q != '0);
  assign head_o.restart = slot_q[rd_ptr_q];

  // Fill level
  always_comb begin
    count_d = count_q;
    unique case ({push, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i) rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= restart_i;
  end

endmodule

// ----- src/ssag_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssag_back
// Walks the slice one element per command and registers the address pair.
// ----------------------------------------------------------------------------
module ssag_back
  import ssag_pkg::*;
#(
  parameter int unsigned INDEX_BITS = 32,
  parameter int unsigned AXIS_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  q_head_t               head_i,
  output logic                  pop_o,
  input  logic [CfgDataW-1:0]   base_i,
  input  logic signed [31:0]    stride_x_i,
  input  logic signed [31:0]    stride_y_i,
  input  logic signed [31:0]    stride_z_i,
  input  logic [AXIS_BITS-1:0]  last_x_i,
  input  logic [AXIS_BITS-1:0]  last_y_i,
  input  logic [AXIS_BITS-1:0]  last_z_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OutIdxW-1:0]    source_index_o,
  output logic [OutIdxW-1:0]    slice_index_o,
  output logic                  last_element_o
);

  localparam int unsigned IW = INDEX_BITS;
  localparam int unsigned AW = AXIS_BITS;

  logic [AW-1:0] x_q, y_q, z_q, x_d, y_d, z_d;
  logic [IW-1:0] elem_q, row_q, plane_q, cnt_q;
  logic [IW-1:0] elem_d, row_d, plane_d, cnt_d;

  // Walk state after an optional restart
  logic [AW-1:0] x_c, y_c, z_c;
  logic [IW-1:0] elem_c, row_c, plane_c, cnt_c;
  logic [IW-1:0] base_ext, sx, sy, sz;
  logic          xe, ye, ze;

  logic              out_valid_q;
  logic [OutIdxW-1:0] src_q, slc_q;
  logic              last_q;

  assign base_ext = IW'(base_i);
  assign sx       = IW'(stride_x_i);
  assign sy       = IW'(stride_y_i);
  assign sz       = IW'(stride_z_i);

  assign pop_o = head_i.valid && (!out_valid_q || out_ready_i);

  // Restart selects the first element of a fresh pass
  always_comb begin
    if (head_i.restart) begin
      x_c     = '0;
      y_c     = '0;
      z_c     = '0;
      elem_c  = base_ext;
      row_c   = base_ext;
      plane_c = base_ext;
      cnt_c   = '0;
    end else begin
      x_c     = x_q;
      y_c     = y_q;
      z_c     = z_q;
      elem_c  = elem_q;
      row_c   = row_q;
      plane_c = plane_q;
      cnt_c   = cnt_q;
    end
  end

  assign xe = (x_c == last_x_i);
  assign ye = (y_c == last_y_i);
  assign ze = (z_c == last_z_i);

  // Advance: x fastest, then y, then z, then wrap to a new pass
  always_comb begin
    x_d     = x_c;
    y_d     = y_c;
    z_d     = z_c;
    elem_d  = elem_c;
    row_d   = row_c;
    plane_d = plane_c;
    cnt_d   = cnt_c + 1'b1;
    priority if (!xe) begin
      x_d    = x_c + 1'b1;
      elem_d = elem_c + sx;
    end else if (!ye) begin
      x_d    = '0;
      y_d    = y_c + 1'b1;
      row_d  = row_c + sy;
      elem_d = row_c + sy;
    end else if (!ze) begin
      x_d     = '0;
      y_d     = '0;
      z_d     = z_c + 1'b1;
      plane_d = plane_c + sz;
      row_d   = plane_c + sz;
      elem_d  = plane_c + sz;
    end else begin
      x_d     = '0;
      y_d     = '0;
      z_d     = '0;
      elem_d  = base_ext;
      row_d   = base_ext;
      plane_d = base_ext;
      cnt_d   = '0;
    end
  end

  // Walk state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q     <= '0;
      y_q     <= '0;
      z_q     <= '0;
      elem_q  <= '0;
      row_q   <= '0;
      plane_q <= '0;
      cnt_q   <= '0;
    end else if (pop_o) begin
      x_q     <= x_d;
      y_q     <= y_d;
      z_q     <= z_d;
      elem_q  <= elem_d;
      row_q   <= row_d;
      plane_q <= plane_d;
      cnt_q   <= cnt_d;
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      src_q  <= OutIdxW'(elem_c);
      slc_q  <= OutIdxW'(cnt_c);
      last_q <= xe && ye && ze;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign source_index_o = src_q;
  assign slice_index_o  = slc_q;
  assign last_element_o = last_q;

endmodule

// ----- src/strided_slice_address_generator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strided_slice_address_generator_core
// Generates source/slice index pairs over a strided 3-axis slice.
// ----------------------------------------------------------------------------
// Usage:
//   Each item on the input channel (in_valid_i/in_ready_o, restart_i) asks for
//   one address pair; restart_i = 1 begins a new pass at the first element.
//   Each item gives exactly one result item on the output channel
//   (out_valid_o/out_ready_i): source_index_o, slice_index_o, last_element_o.
//   Elements are visited x fastest, then y, then z; after the final element
//   the walk wraps to a new pass using the current base_index.
//   An accepted item is written into the two-entry command queue; the walker
//   pops it when the output register is free and loads its result there, where
//   the result waits until the receiver takes it.
//   Throughput: one item per clock while the receiver takes every result, set by
//   the walker update (one index add and three position compares).
//   When the receiver stalls, the result waits in the output register and the
//   queue absorbs up to two more items before in_ready_o drops.
//   Reset clears the walk state (a pass over base 0) and sets the registers
//   to base 0, stride_x 1, other strides 0, all counts 1; counts are stored as
//   count minus one. Configuration is written through cfg_we_i, cfg_index_i and
//   cfg_data_i; the user must do so only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module strided_slice_address_generator_core
  import ssag_pkg::*;
#(
  parameter int unsigned INDEX_BITS = 32,
  parameter int unsigned AXIS_BITS  = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                restart_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutIdxW-1:0]  source_index_o,
  output logic [OutIdxW-1:0]  slice_index_o,
  output logic                last_element_o
);

  localparam int unsigned CW = (AXIS_BITS > CountW) ? AXIS_BITS : CountW;

  logic [CfgDataW-1:0]  base_q;
  logic signed [31:0]   stride_x_q, stride_y_q, stride_z_q;
  logic [AXIS_BITS-1:0] last_x_q, last_y_q, last_z_q;
  logic [AXIS_BITS-1:0] last_wr;
  logic [CW-1:0]        cnt_m1;
  q_head_t              head;
  logic                 pop;

  // Count minus one, wrapped to the axis width (a zero count acts as 2^AXIS_BITS)
  assign cnt_m1  = CW'(cfg_data_i[CountW-1:0]) - 1'b1;
  assign last_wr = cnt_m1[AXIS_BITS-1:0];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q     <= '0;
      stride_x_q <= 32'sd1;
      stride_y_q <= '0;
      stride_z_q <= '0;
      last_x_q   <= '0;
      last_y_q   <= '0;
      last_z_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_BASE_INDEX: base_q     <= cfg_data_i;
        CFG_STRIDE_X:   stride_x_q <= cfg_data_i;
        CFG_STRIDE_Y:   stride_y_q <= cfg_data_i;
        CFG_STRIDE_Z:   stride_z_q <= cfg_data_i;
        CFG_COUNT_X:    last_x_q   <= last_wr;
        CFG_COUNT_Y:    last_y_q   <= last_wr;
        CFG_COUNT_Z:    last_z_q   <= last_wr;
        default:        ;
      endcase
    end
  end

  // Front: accept and queue items
  ssag_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .restart_i  (restart_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  // Back: slice walker and output register
  ssag_back #(
    .INDEX_BITS (INDEX_BITS),
    .AXIS_BITS  (AXIS_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head),
    .pop_o          (pop),
    .base_i         (base_q),
    .stride_x_i     (stride_x_q),
    .stride_y_i     (stride_y_q),
    .stride_z_i     (stride_z_q),
    .last_x_i       (last_x_q),
    .last_y_i       (last_y_q),
    .last_z_i       (last_z_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .source_index_o (source_index_o),
    .slice_index_o  (slice_index_o),
    .last_element_o (last_element_o)
  );

  // A full queue always has a command waiting for the walker
  a_full_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> head.valid)
    else $error("queue full without a head command");

  // The walker only takes a command when one is there
  a_pop_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head.valid)
    else $error("walker took a command from an empty queue");

  // A restart command yields the first slice element next cycle
  a_restart_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && head.restart) |=> (out_valid_o && (slice_index_o == '0)))
    else $error("restart did not produce slice index zero");

endmodule

// ----- tb/sv/strided_slice_address_generator_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strided_slice_address_generator_core_tb
// Self-checking bench for the strided slice address generator.
// A short table of directed items, some with hand-computed results, is
// followed by random phases. Each phase rewrites some registers and then
// sends a burst of items, most of them walking a pass after a restart.
// Every accepted item is run through a local copy of the walk, and every
// result item is compared with the oldest predicted address pair.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module strided_slice_address_generator_core_tb;
  import ssag_pkg::*;

  localparam int unsigned ItemTarget = 1650;
  localparam int unsigned MaxReports = 10;
  // Register index that maps to no register
  localparam logic [CfgIdxW-1:0] CFG_SPARE = 3'd7;

  typedef struct packed {
    logic [OutIdxW-1:0] src;
    logic [OutIdxW-1:0] slc;
    logic               last;
  } addr_pair_t;

  // One row of the directed table: a register write or an item
  typedef struct packed {
    logic                is_write;
    logic [CfgIdxW-1:0]  reg_sel;
    logic [CfgDataW-1:0] wdata;
    logic                restart;
    logic                typed;
    addr_pair_t          want;
  } plan_row_t;

  // DUT connections
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic                restart_i   = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [OutIdxW-1:0]  source_index_o;
  logic [OutIdxW-1:0]  slice_index_o;
  logic                last_element_o;

  // Hand-computed result that travels with a directed item
  logic       hint_on = 1'b0;
  addr_pair_t hint    = '0;

  // Register mirror, reset values
  logic [31:0]        base_addr = 32'd0;
  logic signed [31:0] step_x    = 32'sd1;
  logic signed [31:0] step_y    = 32'sd0;
  logic signed [31:0] step_z    = 32'sd0;
  logic [15:0]        cnt_x     = 16'd1;
  logic [15:0]        cnt_y     = 16'd1;
  logic [15:0]        cnt_z     = 16'd1;

  // Walk state, zero after reset
  logic [15:0] col_pos     = '0;
  logic [15:0] row_pos     = '0;
  logic [15:0] plane_pos   = '0;
  logic [31:0] elem_addr   = '0;
  logic [31:0] row_addr    = '0;
  logic [31:0] plane_addr  = '0;
  logic [31:0] slice_count = '0;

  addr_pair_t pairs_due[$];
  plan_row_t  plan[$];
  int         items_sent = 0;
  int         errors     = 0;
  int         send_calm  = 0;
  int         recv_calm  = 0;

  strided_slice_address_generator_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .restart_i      (restart_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .source_index_o (source_index_o),
    .slice_index_o  (slice_index_o),
    .last_element_o (last_element_o)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit, several times the slowest legal run
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // Rewind the walk to the first element of a pass
  function automatic void begin_pass();
    col_pos     = '0;
    row_pos     = '0;
    plane_pos   = '0;
    elem_addr   = base_addr;
    row_addr    = base_addr;
    plane_addr  = base_addr;
    slice_count = '0;
  endfunction

  // Address pair for one item, then advance the walk
  function automatic addr_pair_t next_address(logic restart);
    addr_pair_t res;
    logic       x_done;
    logic       y_done;
    logic       z_done;
    if (restart) begin_pass();
    // counts compare as count minus one, so zero means 2^16
    x_done   = (col_pos == cnt_x - 16'd1);
    y_done   = (row_pos == cnt_y - 16'd1);
    z_done   = (plane_pos == cnt_z - 16'd1);
    res.src  = elem_addr;
    res.slc  = slice_count;
    res.last = x_done & y_done & z_done;
    if (!x_done) begin
      col_pos     = col_pos + 16'd1;
      elem_addr   = elem_addr + step_x;
      slice_count = slice_count + 32'd1;
    end else if (!y_done) begin
      col_pos     = '0;
      row_pos     = row_pos + 16'd1;
      row_addr    = row_addr + step_y;
      elem_addr   = row_addr;
      slice_count = slice_count + 32'd1;
    end else if (!z_done) begin
      col_pos     = '0;
      row_pos     = '0;
      plane_pos   = plane_pos + 16'd1;
      plane_addr  = plane_addr + step_z;
      row_addr    = plane_addr;
      elem_addr   = plane_addr;
      slice_count = slice_count + 32'd1;
    end else begin
      begin_pass();
    end
    return res;
  endfunction

  // Predict on accepted items, check accepted results
  always @(posedge clk_i) begin
    addr_pair_t pred;
    addr_pair_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        pred = next_address(restart_i);
        pairs_due.push_back(hint_on ? hint : pred);
      end
      if (out_valid_o && out_ready_i) begin
        if (pairs_due.size() == 0) begin
          errors++;
          if (errors <= MaxReports)
            $display("unexpected result: src=%h slc=%h last=%b",
                     source_index_o, slice_index_o, last_element_o);
        end else begin
          want = pairs_due.pop_front();
          if (source_index_o !== want.src || slice_index_o !== want.slc ||
              last_element_o !== want.last) begin
            errors++;
            if (errors <= MaxReports)
              $display("mismatch: expected src=%h slc=%h last=%b, got src=%h slc=%h last=%b",
                       want.src, want.slc, want.last,
                       source_index_o, slice_index_o, last_element_o);
          end
        end
      end
    end
  end

  // Wait count per item, with occasional stretches of no idling
  task automatic draw_wait(inout int calm_left, output int cycles);
    if (calm_left > 0) begin
      calm_left--;
      cycles = 0;
    end else if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(8, 40);
      cycles    = 0;
    end else begin
      cycles = $urandom_range(0, 17);
    end
  endtask

  // Receiver: stall before each result item
  initial begin
    int stall;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      draw_wait(recv_calm, stall);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Drive one item and hold it until accepted
  task automatic push_item(input logic rs, input logic typed, input addr_pair_t want);
    int gap;
    cfg_we_i <= 1'b0;
    draw_wait(send_calm, gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= rs;
    hint_on    <= typed;
    hint       <= want;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  // Let every outstanding result drain
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pairs_due.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Register write, mirrored for the predictor
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    case (idx)
      CFG_BASE_INDEX: base_addr = data;
      CFG_STRIDE_X:   step_x    = data;
      CFG_STRIDE_Y:   step_y    = data;
      CFG_STRIDE_Z:   step_z    = data;
      CFG_COUNT_X:    cnt_x     = data[15:0];
      CFG_COUNT_Y:    cnt_y     = data[15:0];
      CFG_COUNT_Z:    cnt_z     = data[15:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  function automatic void plan_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    plan_row_t r;
    r          = '0;
    r.is_write = 1'b1;
    r.reg_sel  = idx;
    r.wdata    = data;
    plan.push_back(r);
  endfunction

  function automatic void plan_item(logic rs, logic typed = 1'b0, logic [31:0] src = '0,
                                    logic [31:0] slc = '0, logic last = 1'b0);
    plan_row_t r;
    r           = '0;
    r.restart   = rs;
    r.typed     = typed;
    r.want.src  = src;
    r.want.slc  = slc;
    r.want.last = last;
    plan.push_back(r);
  endfunction

  // Random register values, biased to the extremes
  function automatic logic [31:0] pick_base();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_stride();
    int v;
    v = int'($urandom_range(0, 16)) - 8;
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2, 3:    return v;
      default: return $urandom();
    endcase
  endfunction

  // Mostly tiny counts so passes wrap often; upper data bits are don't-care
  function automatic logic [31:0] pick_count();
    logic [15:0] n;
    case ($urandom_range(0, 11))
      0:       n = 16'h0000;
      1:       n = 16'hFFFF;
      2:       n = 16'($urandom_range(5, 300));
      default: n = 16'($urandom_range(1, 4));
    endcase
    return {16'($urandom()), n};
  endfunction

  // Stimulus
  initial begin
    logic                busy;
    logic                rs;
    logic [CfgIdxW-1:0]  sel;
    logic [CfgDataW-1:0] data;
    int                  burst;

    // reset state: every item is a one-element pass over base 0
    plan_item(1'b0, 1'b1, 32'h0, 32'h0, 1'b1);
    plan_item(1'b0, 1'b1, 32'h0, 32'h0, 1'b1);
    plan_item(1'b1, 1'b1, 32'h0, 32'h0, 1'b1);
    // 2x2x2 with top base and extreme strides, wrap and mid-pass restart
    plan_write(CFG_BASE_INDEX, 32'hFFFF_FFFF);
    plan_write(CFG_STRIDE_X,   32'h8000_0000);
    plan_write(CFG_STRIDE_Y,   32'h7FFF_FFFF);
    plan_write(CFG_STRIDE_Z,   32'h0000_0001);
    plan_write(CFG_COUNT_X,    32'h0000_0002);
    plan_write(CFG_COUNT_Y,    32'h0000_0002);
    plan_write(CFG_COUNT_Z,    32'h0000_0002);
    plan_write(CFG_SPARE,      32'hA5A5_5A5A);
    plan_item(1'b1, 1'b1, 32'hFFFF_FFFF, 32'h0, 1'b0);
    repeat (6) plan_item(1'b0);
    plan_item(1'b0, 1'b1, 32'hFFFF_FFFF, 32'h7, 1'b1);
    plan_item(1'b0);
    plan_item(1'b0);
    plan_item(1'b1);
    // zero counts act as 2^16, all-ones count, junk in upper data bits
    plan_write(CFG_BASE_INDEX, 32'h0000_0000);
    plan_write(CFG_STRIDE_X,   32'h7FFF_FFFF);
    plan_write(CFG_STRIDE_Y,   32'hFFFF_FFFF);
    plan_write(CFG_STRIDE_Z,   32'h8000_0000);
    plan_write(CFG_COUNT_X,    32'h0000_0000);
    plan_write(CFG_COUNT_Y,    32'hFFFF_FFFF);
    plan_write(CFG_COUNT_Z,    32'h0000_0000);
    plan_item(1'b1, 1'b1, 32'h0, 32'h0, 1'b0);
    repeat (3) plan_item(1'b0);
    // shrink count_x below the current x position, no restart
    plan_write(CFG_COUNT_X, 32'h0000_0001);
    repeat (2) plan_item(1'b0);
    plan_write(CFG_COUNT_X,  32'hFFFF_0003);
    plan_write(CFG_COUNT_Y,  32'h0000_0001);
    plan_write(CFG_COUNT_Z,  32'h0000_0001);
    plan_write(CFG_STRIDE_X, 32'h0000_0001);
    repeat (2) plan_item(1'b0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    busy = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        if (busy) wait_idle();
        busy = 1'b0;
        write_reg(plan[i].reg_sel, plan[i].wdata);
      end else begin
        busy = 1'b1;
        push_item(plan[i].restart, plan[i].typed, plan[i].want);
      end
    end

    // random phases: new settings, then a burst that mostly walks a pass
    while (items_sent < ItemTarget) begin
      wait_idle();
      for (int r = 0; r < (1 << CfgIdxW); r++) begin
        sel = r[CfgIdxW-1:0];
        case (sel)
          CFG_BASE_INDEX:                          data = pick_base();
          CFG_STRIDE_X, CFG_STRIDE_Y, CFG_STRIDE_Z: data = pick_stride();
          CFG_COUNT_X, CFG_COUNT_Y, CFG_COUNT_Z:    data = pick_count();
          default:                                 data = $urandom();
        endcase
        if (sel == CFG_SPARE ? ($urandom_range(0, 7) == 0) : ($urandom_range(0, 1) == 1))
          write_reg(sel, data);
      end
      burst = $urandom_range(4, 60);
      for (int k = 0; k < burst; k++) begin
        if (k == 0) rs = ($urandom_range(0, 3) != 0);
        else        rs = ($urandom_range(0, 24) == 0);
        push_item(rs, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
